// ----- rtl/set_assoc_cache_lru_controller_top_defines.svh -----
// Assertion macros shared by the checker of the cache controller.
// Depends on nothing; included by the checker file.
`ifndef SET_ASSOC_CACHE_LRU_CONTROLLER_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_CONTROLLER_TOP_DEFINES_SVH
// Concurrent assertion checked on the rising clock edge outside reset.
`define SACL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same, but also checked during reset.
`define SACL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/sacl_pkg.sv -----
// Package of the cache controller: sizes, register indexes, command encodings and a helper function.
// Depends on nothing; used by the top, the way logic and the testbench.
package sacl_pkg;
  localparam int MAX_SETS_C       = 256;
  localparam int MAX_WAYS_C       = 8;
  localparam int MAX_LINE_BYTES_C = 64;
  localparam int ADDR_BITS_C      = 32;
  localparam int CFG_W            = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int AGE_W            = 8;
  localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_BITS     = 3'd0,
    REG_SET_BITS       = 3'd1,
    REG_WAY_BITS       = 3'd2,
    REG_WRITE_THROUGH  = 3'd3,
    REG_WRITE_ALLOCATE = 3'd4
  } cfg_reg_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  function automatic int clog2_min1(input int v);
    int r;
    r = $clog2(v);
    return (r < 1) ? 1 : r;
  endfunction
endpackage

// ----- rtl/set_assoc_cache_lru_controller_top.sv -----
// Cache controller top: the set is read at the accepting edge, then resolved and written back
// in the next cycle, which loads the result register.
// A new request is taken only after the last one is resolved, due to the read-modify-write of
// the set memory; a stalled result moves to a hold register, and requests also stop while it is full.
// Reset runs a clearing pass over every set and sets the registers to 6, 8, 3, 0, 1.
// Depends on sacl_pkg, sacl_ram and sacl_way_logic.
module set_assoc_cache_lru_controller_top #(
  parameter int MAX_SETS       = sacl_pkg::MAX_SETS_C,
  parameter int MAX_WAYS       = sacl_pkg::MAX_WAYS_C,
  parameter int MAX_LINE_BYTES = sacl_pkg::MAX_LINE_BYTES_C,
  parameter int ADDR_BITS      = sacl_pkg::ADDR_BITS_C
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [31:0]                   in_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_fetch_line,
  output logic                          out_write_lower,
  output logic                          out_writeback_valid,
  output logic [31:0]                   out_victim_line_address,
  output logic [63:0]                   out_dirty_mask
);
  import sacl_pkg::*;

  localparam int SW    = clog2_min1(MAX_SETS);
  localparam int WW    = clog2_min1(MAX_WAYS);
  localparam int LB    = $clog2(MAX_SETS);
  localparam int LW    = $clog2(MAX_WAYS);
  localparam int LL    = $clog2(MAX_LINE_BYTES);
  localparam int TAG_W = ADDR_BITS;
  localparam int ENT_W = 1 + AGE_W + 64 + TAG_W;
  localparam int SET_W = MAX_WAYS * ENT_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;
  state_t state_r;

  logic [2:0] block_bits_r;
  logic [3:0] set_bits_r;
  logic [1:0] way_bits_r;
  logic       write_through_r, write_allocate_r;
  logic [SW-1:0] clr_cnt_r;
  logic          cmd_r;
  logic [ADDR_BITS-1:0] addr_r;

  logic        hold_valid_r;
  logic        hold_hit_r, hold_fetch_r, hold_wl_r, hold_wb_r;
  logic [31:0] hold_vaddr_r;
  logic [63:0] hold_mask_r;

  logic [2:0] b;
  logic [3:0] s;
  logic [1:0] e;
  always_comb begin
    b = (32'(block_bits_r) > LL) ? 3'(LL) : block_bits_r;
    s = (32'(set_bits_r) > LB) ? 4'(LB) : set_bits_r;
    e = (32'(way_bits_r) > LW) ? 2'(LW) : way_bits_r;
  end

  logic [ADDR_BITS-1:0] in_addr_ext;
  assign in_addr_ext = ADDR_BITS'({32'd0, in_address});

  function automatic logic [SW-1:0] set_of(input logic [ADDR_BITS-1:0] a,
                                           input logic [2:0] bb, input logic [3:0] ss);
    logic [ADDR_BITS-1:0] t;
    t = (a >> bb) & ((ADDR_BITS'(1) << ss) - ADDR_BITS'(1));
    return SW'(t);
  endfunction

  // Memory: one word per set holding every way.
  logic             mem_we;
  logic [SW-1:0]    mem_waddr, mem_raddr;
  logic [SET_W-1:0] mem_wdata, mem_rdata;

  sacl_ram #(.WIDTH(SET_W), .DEPTH(1 << SW)) u_set_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic [MAX_WAYS-1:0]                valid_v;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     age_v;
  logic [MAX_WAYS-1:0][63:0]          dirty_v;
  logic [MAX_WAYS-1:0][TAG_W-1:0]     tag_v;
  logic [MAX_WAYS-1:0]                way_en;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      {valid_v[i], age_v[i], dirty_v[i], tag_v[i]} = mem_rdata[i*ENT_W +: ENT_W];
      way_en[i] = (32'(i) < (32'd1 << e));
    end
  end

  logic [TAG_W-1:0] cur_tag;
  logic [SW-1:0]    cur_set;
  logic [5:0]       cur_off;
  assign cur_tag = addr_r >> (32'(b) + 32'(s));
  assign cur_set = set_of(addr_r, b, s);
  assign cur_off = 6'(addr_r & ((ADDR_BITS'(1) << b) - ADDR_BITS'(1)));

  logic          hit;
  logic [WW-1:0] hit_way, victim_way;

  sacl_way_logic #(.MAX_WAYS(MAX_WAYS), .TAG_W(TAG_W)) u_ways (
    .valid(valid_v), .tags(tag_v), .ages(age_v), .way_en(way_en), .tag(cur_tag),
    .hit(hit), .hit_way(hit_way), .victim_way(victim_way)
  );

  logic          alloc, present;
  logic [WW-1:0] way;
  logic [63:0]   line_mask, vdirty;
  logic [ADDR_BITS-1:0] vaddr;
  logic [SET_W-1:0] new_set;
  logic          res_wl, res_wb;
  logic [31:0]   res_vaddr;

  always_comb begin
    logic [63:0] dnew;
    logic        vn;
    logic [AGE_W-1:0] an;
    logic [TAG_W-1:0] tn;
    alloc   = !hit && (cmd_r == CMD_READ || write_allocate_r);
    present = hit || alloc;
    way     = hit ? hit_way : victim_way;
    line_mask = (b >= 3'd6) ? '1 : ((64'd1 << (7'd1 << b)) - 64'd1);
    vdirty  = (alloc && valid_v[way]) ? (dirty_v[way] & line_mask) : 64'd0;
    vaddr   = (tag_v[way] << (32'(b) + 32'(s))) |
              (ADDR_BITS'(cur_set) << b);
    res_wl  = (cmd_r == CMD_WRITE) && (write_through_r || !present);
    res_wb  = (vdirty != 64'd0);
    res_vaddr = res_wb ? 32'(vaddr) : 32'd0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      vn = valid_v[i]; an = age_v[i]; dnew = dirty_v[i]; tn = tag_v[i];
      if (present && way_en[i]) begin
        if (WW'(i) == way) begin
          an = '0;
          if (alloc) begin
            vn = 1'b1; tn = cur_tag; dnew = 64'd0;
          end
          if (cmd_r == CMD_WRITE && !write_through_r) begin
            dnew = dnew | (64'd1 << cur_off);
          end
        end else if (valid_v[i] && age_v[i] != AGE_MAX) begin
          an = age_v[i] + AGE_W'(1);
        end
      end
      new_set[i*ENT_W +: ENT_W] = {vn, an, dnew, tn};
    end
  end

  logic accept;
  assign in_stall = (state_r != ST_IDLE) || hold_valid_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mem_raddr = set_of(in_addr_ext, b, s);
    mem_we    = 1'b0;
    mem_waddr = cur_set;
    mem_wdata = new_set;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1; mem_waddr = clr_cnt_r; mem_wdata = '0;
    end else if (state_r == ST_LOOK) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_cnt_r <= '0;
      out_valid <= 1'b0;
      hold_valid_r <= 1'b0;
      block_bits_r <= 3'd6; set_bits_r <= 4'd8; way_bits_r <= 2'd3;
      write_through_r <= 1'b0; write_allocate_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_BITS:     block_bits_r <= cfg_data[2:0];
          REG_SET_BITS:       set_bits_r <= cfg_data[3:0];
          REG_WAY_BITS:       way_bits_r <= cfg_data[1:0];
          REG_WRITE_THROUGH:  write_through_r <= cfg_data[0];
          REG_WRITE_ALLOCATE: write_allocate_r <= cfg_data[0];
          default: ;
        endcase
      end
      // A new result parks in the hold register while the output one is stalled.
      if (state_r == ST_LOOK && out_valid && out_stall) begin
        hold_valid_r <= 1'b1;
        hold_hit_r <= hit;
        hold_fetch_r <= alloc;
        hold_wl_r <= res_wl;
        hold_wb_r <= res_wb;
        hold_vaddr_r <= res_vaddr;
        hold_mask_r <= vdirty;
      end else if (state_r == ST_LOOK) begin
        out_valid <= 1'b1;
        out_hit <= hit;
        out_fetch_line <= alloc;
        out_write_lower <= res_wl;
        out_writeback_valid <= res_wb;
        out_victim_line_address <= res_vaddr;
        out_dirty_mask <= vdirty;
      end else if (hold_valid_r && (!out_valid || !out_stall)) begin
        hold_valid_r <= 1'b0;
        out_valid <= 1'b1;
        out_hit <= hold_hit_r;
        out_fetch_line <= hold_fetch_r;
        out_write_lower <= hold_wl_r;
        out_writeback_valid <= hold_wb_r;
        out_victim_line_address <= hold_vaddr_r;
        out_dirty_mask <= hold_mask_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + SW'(1);
          if (32'(clr_cnt_r) == (1 << SW) - 1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r <= in_cmd;
            addr_r <= in_addr_ext;
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/sacl_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Depends on nothing.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/sacl_way_logic.sv -----
// Combinational lookup and victim choice over one set's ways.
// Depends on sacl_pkg.
module sacl_way_logic #(
  parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_C,
  parameter int TAG_W     = 32
) (
  input  logic [MAX_WAYS-1:0]                   valid,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]        tags,
  input  logic [MAX_WAYS-1:0][sacl_pkg::AGE_W-1:0] ages,
  input  logic [MAX_WAYS-1:0]                   way_en,
  input  logic [TAG_W-1:0]                      tag,
  output logic                                  hit,
  output logic [sacl_pkg::clog2_min1(MAX_WAYS)-1:0] hit_way,
  output logic [sacl_pkg::clog2_min1(MAX_WAYS)-1:0] victim_way
);
  import sacl_pkg::*;
  localparam int WW = clog2_min1(MAX_WAYS);

  logic found_inv;
  logic [AGE_W-1:0] best_age;

  // Hit takes the lowest matching way; victim is highest invalid way, else oldest.
  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (way_en[i] && valid[i] && tags[i] == tag) begin
        hit = 1'b1;
        hit_way = WW'(i);
      end
    end
    found_inv = 1'b0;
    victim_way = '0;
    best_age = ages[0];
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (way_en[i] && !valid[i]) begin
        found_inv = 1'b1;
        victim_way = WW'(i);
      end
    end
    if (!found_inv) begin
      for (int i = 1; i < MAX_WAYS; i++) begin
        if (way_en[i] && ages[i] > best_age) begin
          best_age = ages[i];
          victim_way = WW'(i);
        end
      end
    end
  end
endmodule

// ----- rtl/sacl_checker.sv -----
// Port-level checker of the cache controller, bound to the top level.
// Depends on the assertion macro header.
`include "set_assoc_cache_lru_controller_top_defines.svh"
module sacl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic        out_fetch_line,
  input logic        out_writeback_valid,
  input logic [63:0] out_dirty_mask
);
  logic wb_ok;
  assign wb_ok = out_fetch_line && (out_dirty_mask != 64'd0);

  // A hit never fetches a line.
  `SACL_ASSERT(a_hit_no_fetch, out_valid |-> !(out_hit && out_fetch_line), "hit with fetch")
  // A write-back needs an allocation and a nonzero mask.
  `SACL_ASSERT(a_wb_fetch, (out_valid && out_writeback_valid) |-> wb_ok, "bad writeback")
  // Back-to-back requests are never accepted.
  `SACL_ASSERT(a_rate, (in_valid && !in_stall) |=> in_stall, "back-to-back accept")
  // A stalled result holds.
  `SACL_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_dirty_mask)), "result dropped")
  // No result during reset.
  `SACL_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result after reset")
endmodule

bind set_assoc_cache_lru_controller_top sacl_checker u_sacl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
  .out_fetch_line(out_fetch_line), .out_writeback_valid(out_writeback_valid),
  .out_dirty_mask(out_dirty_mask)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the set-associative cache controller: directed and random
// requests under several cache geometries, checked against an in-bench LRU/dirty predictor.
// Depends on sacl_pkg and set_assoc_cache_lru_controller_top.
module tb_top;
  import sacl_pkg::*;

  localparam int IDLE_PCT   = 34;
  localparam int HANG_LIMIT = 6000;
  localparam int PHASES     = 7;
  localparam int PER_PHASE  = 250;

  typedef struct packed {
    logic        hit;
    logic        fetch_line;
    logic        write_lower;
    logic        writeback_valid;
    logic [31:0] victim_line_address;
    logic [63:0] dirty_mask;
  } access_res_t;

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    bit          typed;
    logic        hit;
    logic        fetch_line;
    logic        write_lower;
  } access_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_READ;
  logic [31:0] in_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit, out_fetch_line, out_write_lower, out_writeback_valid;
  logic [31:0] out_victim_line_address;
  logic [63:0] out_dirty_mask;

  set_assoc_cache_lru_controller_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: one entry per set and way, indexed set * MAX_WAYS_C + way.
  logic [31:0] tag_mem   [MAX_SETS_C*MAX_WAYS_C];
  bit          valid_mem [MAX_SETS_C*MAX_WAYS_C];
  logic [7:0]  age_mem   [MAX_SETS_C*MAX_WAYS_C];
  logic [63:0] dirty_mem [MAX_SETS_C*MAX_WAYS_C];
  logic [2:0]  blk_cfg = 3'd6;
  logic [3:0]  set_cfg = 4'd8;
  logic [1:0]  way_cfg = 2'd3;
  logic        wthru_cfg = 1'b0;
  logic        walloc_cfg = 1'b1;

  access_res_t pending_results[$];
  int  failures = 0, results_seen = 0, hits_seen = 0, evictions_seen = 0, sent = 0;
  bit  calm = 1'b0;
  int  hang_count = 0;

  function automatic void age_set(int base, int ways, int way);
    for (int i = 0; i < ways; i++) begin
      if (i == way) age_mem[base+i] = 8'd0;
      else if (valid_mem[base+i] && age_mem[base+i] < AGE_MAX) age_mem[base+i]++;
    end
  endfunction

  function automatic access_res_t predict_access(logic cmd, logic [31:0] a);
    int b, s, ways, base, way, offset;
    logic [31:0] set_idx, tag;
    logic [63:0] line_mask, d;
    bit hit, present, found;
    access_res_t r;
    b = (blk_cfg > 6) ? 6 : blk_cfg;
    s = (set_cfg > 8) ? 8 : set_cfg;
    ways = 1 << way_cfg;
    line_mask = (b >= 6) ? '1 : ((64'd1 << (1 << b)) - 64'd1);
    offset = a & ((32'd1 << b) - 1);
    set_idx = (a >> b) & ((32'd1 << s) - 1);
    tag = a >> (b + s);
    base = set_idx * MAX_WAYS_C;
    r = '0;
    hit = 0;
    present = 0;
    way = 0;
    for (int i = 0; i < ways; i++) begin
      if (!hit && valid_mem[base+i] && tag_mem[base+i] == tag) begin
        hit = 1;
        way = i;
      end
    end
    if (hit) begin
      age_set(base, ways, way);
      present = 1;
    end else if (cmd == CMD_READ || walloc_cfg) begin
      found = 0;
      for (int i = 0; i < ways; i++)
        if (!valid_mem[base+i]) begin
          way = i;
          found = 1;
        end
      if (!found) begin
        way = 0;
        for (int i = 1; i < ways; i++)
          if (age_mem[base+i] > age_mem[base+way]) way = i;
      end
      d = valid_mem[base+way] ? (dirty_mem[base+way] & line_mask) : 64'd0;
      if (d != 0) begin
        r.writeback_valid = 1;
        r.dirty_mask = d;
        r.victim_line_address = (tag_mem[base+way] << (b + s)) | (set_idx << b);
      end
      tag_mem[base+way] = tag;
      valid_mem[base+way] = 1;
      dirty_mem[base+way] = '0;
      age_set(base, ways, way);
      r.fetch_line = 1;
      present = 1;
    end
    if (cmd == CMD_WRITE) begin
      if (wthru_cfg || !present) r.write_lower = 1;
      else dirty_mem[base+way] |= 64'd1 << offset;
    end
    r.hit = hit;
    return r;
  endfunction

  // Drive one request from a falling edge and hold it until it is accepted.
  task automatic send_access(logic cmd, logic [31:0] a, bit typed, access_res_t typed_res);
    access_res_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_address = a;
    do @(posedge clk); while (in_stall);
    r = predict_access(cmd, a);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    case (idx)
      REG_BLOCK_BITS:     blk_cfg = v[2:0];
      REG_SET_BITS:       set_cfg = v[3:0];
      REG_WAY_BITS:       way_cfg = v[1:0];
      REG_WRITE_THROUGH:  wthru_cfg = v[0];
      REG_WRITE_ALLOCATE: walloc_cfg = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver stall and result check.
  always @(negedge clk)
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

  always @(posedge clk) begin
    access_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        e = pending_results.pop_front();
        results_seen++;
        hits_seen += out_hit;
        evictions_seen += out_writeback_valid;
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_hit);
          failures++;
        end
        if (out_fetch_line !== e.fetch_line) begin
          $error("fetch_line: expected %0d, got %0d", e.fetch_line, out_fetch_line);
          failures++;
        end
        if (out_write_lower !== e.write_lower) begin
          $error("write_lower: expected %0d, got %0d", e.write_lower, out_write_lower);
          failures++;
        end
        if (out_writeback_valid !== e.writeback_valid) begin
          $error("writeback_valid: expected %0d, got %0d", e.writeback_valid,
                 out_writeback_valid);
          failures++;
        end
        if (out_victim_line_address !== e.victim_line_address) begin
          $error("victim_line_address: expected %h, got %h", e.victim_line_address,
                 out_victim_line_address);
          failures++;
        end
        if (out_dirty_mask !== e.dirty_mask) begin
          $error("dirty_mask: expected %h, got %h", e.dirty_mask, out_dirty_mask);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) hang_count <= 0;
    else hang_count <= hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_address();
    int b, s, sh;
    logic [31:0] a;
    b = (blk_cfg > 6) ? 6 : blk_cfg;
    s = (set_cfg > 8) ? 8 : set_cfg;
    sh = b + s;
    if ($urandom_range(9) < 2) return $urandom();
    // A small pool of tags and sets keeps hits, conflicts and evictions frequent.
    a = $urandom();
    a = (a & ((32'd1 << b) - 1)) | (32'($urandom_range(3)) << b)
        | (32'($urandom_range(11)) << sh);
    if ($urandom_range(9) == 0) a |= 32'hFFFF_FFFF << sh;
    return a;
  endfunction

  access_row_t rows[$];

  initial begin
    access_res_t t;
    logic [3:0] phase_cfg[PHASES][5];
    for (int i = 0; i < MAX_SETS_C*MAX_WAYS_C; i++) begin
      valid_mem[i] = 0;
      age_mem[i] = '0;
      dirty_mem[i] = '0;
      tag_mem[i] = '0;
    end
    phase_cfg = '{'{6, 8, 3, 0, 1}, '{0, 0, 0, 0, 0}, '{7, 15, 3, 1, 1},
                  '{2, 3, 1, 0, 0}, '{6, 0, 2, 1, 0}, '{3, 8, 0, 0, 1},
                  '{5, 2, 3, 0, 1}};
    // After reset: miss fills, hits, a write hit marks a byte dirty.
    rows.insert(rows.size(), '{CMD_READ,  32'h0000_0000, 1, 0, 1, 0});
    rows.insert(rows.size(), '{CMD_WRITE, 32'h0000_003F, 1, 1, 0, 0});
    rows.insert(rows.size(), '{CMD_READ,  32'hFFFF_FFFF, 1, 0, 1, 0});
    rows.insert(rows.size(), '{CMD_WRITE, 32'hFFFF_FFC0, 1, 1, 0, 0});
    rows.insert(rows.size(), '{CMD_READ,  32'h0000_0000, 1, 1, 0, 0});
    // Eight more lines in set 0 fill its free ways, and the last evicts the dirty line at address 0.
    for (int k = 1; k <= 8; k++)
      rows.insert(rows.size(),
                  '{(k % 2) ? CMD_WRITE : CMD_READ, 32'(k) << 14 | 32'(k), 0, 0, 0, 0});
    rows.insert(rows.size(), '{CMD_READ,  32'h0000_0000, 0, 0, 0, 0});
    rows.insert(rows.size(), '{CMD_WRITE, 32'hFFFF_FFFF, 0, 0, 0, 0});
    rows.insert(rows.size(), '{CMD_WRITE, 32'h7FFF_C000, 0, 0, 0, 0});
    rows.insert(rows.size(), '{CMD_READ,  32'h8000_3FC0, 0, 0, 0, 0});

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      if (p != 0) drain();
      for (int r = 0; r < 5; r++) write_reg(cfg_reg_t'(r), phase_cfg[p][r]);
      if (p == 0)
        foreach (rows[i]) begin
          t = '0;
          t.hit = rows[i].hit;
          t.fetch_line = rows[i].fetch_line;
          t.write_lower = rows[i].write_lower;
          send_access(rows[i].cmd, rows[i].addr, rows[i].typed, t);
        end
      for (int n = 0; n < PER_PHASE; n++)
        send_access(1'($urandom_range(1)), pick_address(), 0, '0);
    end
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Ran %0d requests over %0d cache geometries and write policies.", sent, PHASES);
    $display("Results checked: %0d, hits %0d, dirty evictions %0d.", results_seen,
             hits_seen, evictions_seen);
    if (failures == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
